/* sv/boot_keyboard_report_events_core_assert.svh */
// Assertion macros shared by the boot keyboard report event core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BOOT_KEYBOARD_REPORT_EVENTS_CORE_ASSERT_SVH
`define BOOT_KEYBOARD_REPORT_EVENTS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BKRE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BKRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bkre_pkg.sv */
// Package for the boot keyboard report event core: constants, status codes
// and the work entry passed from the classifier to the event sequencer.
`default_nettype none
package bkre_pkg;

  localparam int ALL_SLOTS = 6;
  localparam int KEY_SLOTS_DEF = 6;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam logic [7:0] REPORT_BYTES = 8'd8;
  localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
  localparam logic [7:0] ERR_LOW = 8'd1;
  localparam logic [7:0] ERR_HIGH = 8'd3;
  localparam logic [4:0] LIMIT_RESET = 5'd20;

  typedef enum logic [1:0] {
    ST_EVENT    = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef logic [7:0] usage_t;

  // One classified report. Masks are zero for status entries.
  typedef struct packed {
    status_t                     status;
    logic [7:0]                  mod_diff;
    logic [7:0]                  mod_new;
    logic [ALL_SLOTS-1:0]        rel_mask;
    logic [ALL_SLOTS-1:0]        prs_mask;
    usage_t [ALL_SLOTS-1:0]      old_keys;
    usage_t [ALL_SLOTS-1:0]      new_keys;
  } work_t;

endpackage
`default_nettype wire

/* sv/bkre_if.sv */
// Channel interfaces of the boot keyboard report event core: the report
// channel and the event channel. No dependencies.
`default_nettype none
interface bkre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_length;
  logic [7:0] modifier_bits;
  logic [7:0] reserved_byte;
  logic [7:0] key_slot_0;
  logic [7:0] key_slot_1;
  logic [7:0] key_slot_2;
  logic [7:0] key_slot_3;
  logic [7:0] key_slot_4;
  logic [7:0] key_slot_5;

  modport source (
    output valid, report_length, modifier_bits, reserved_byte,
    output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    input  ready
  );
  modport sink (
    input  valid, report_length, modifier_bits, reserved_byte,
    input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
    output ready
  );
endinterface

interface bkre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_usage;
  logic       key_down;
  logic [1:0] result_status;
  logic       last_event;

  modport source (
    output valid, event_usage, key_down, result_status, last_event,
    input  ready
  );
  modport sink (
    input  valid, event_usage, key_down, result_status, last_event,
    output ready
  );
endinterface
`default_nettype wire

/* sv/boot_keyboard_report_events_core.sv */
// Top level of the boot keyboard report event core: classifier, work queue
// and event sequencer. Depends on bkre_pkg, bkre_if and the bkre_* modules.
//
//   channel | direction | beat
//   rpt     | sink      | one 8-byte boot keyboard report
//   evt     | source    | one key event or one status result
//   cfg     | write     | event_limit, 5 bits, written when cfg_we is high
//
// A report is classified in the cycle it is accepted; reports are taken one per
// cycle while the work queue has room (QUEUE_DEPTH entries).
// The sequencer sends one beat per cycle while evt is ready: one beat per change
// of a report, one for a status result. A report's first beat passes through the
// work queue, the work register and the output register before it appears on evt.
// Reset is synchronous and clears the stored report and sets the limit to 20; a
// stall on evt backs up into the queue and then holds rpt.ready low.
`default_nettype none
module boot_keyboard_report_events_core import bkre_pkg::*; #(
  parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bkre_in_if.sink    rpt,
  bkre_out_if.source evt,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data
);

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  work_t q_in;
  work_t q_head;

  bkre_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rpt      (rpt),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  bkre_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bkre_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .evt     (evt)
  );

endmodule
`default_nettype wire

/* sv/bkre_front.sv */
// Report classifier: checks each report, compares it with the stored one and
// queues an entry if it is invalid or changed. Depends on bkre_pkg, bkre_in_if.
`default_nettype none
module bkre_front import bkre_pkg::*; #(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bkre_in_if.sink    rpt,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic       q_full,
  output logic       q_push,
  output work_t      q_data
);

  logic [4:0] event_limit;
  logic [7:0] prev_mods;
  usage_t     prev_keys [KEY_SLOTS];

  usage_t               cur [ALL_SLOTS];
  logic                 ok;
  logic [7:0]           mod_diff;
  logic [ALL_SLOTS-1:0] rel;
  logic [ALL_SLOTS-1:0] prs;
  logic [4:0]           needed;
  logic                 overflow;
  logic                 accept;

  always_comb begin
    logic held;
    cur[0] = rpt.key_slot_0;
    cur[1] = rpt.key_slot_1;
    cur[2] = rpt.key_slot_2;
    cur[3] = rpt.key_slot_3;
    cur[4] = rpt.key_slot_4;
    cur[5] = rpt.key_slot_5;

    // Every slot is checked, even those beyond the stored ones.
    ok = (rpt.report_length == REPORT_BYTES) && (rpt.reserved_byte == 8'd0);
    for (int i = 0; i < ALL_SLOTS; i++) begin
      if (cur[i] >= ERR_LOW && cur[i] <= ERR_HIGH) begin
        ok = 1'b0;
      end
      for (int j = i + 1; j < ALL_SLOTS; j++) begin
        if (cur[i] != 8'd0 && cur[i] == cur[j]) begin
          ok = 1'b0;
        end
      end
    end

    mod_diff = prev_mods ^ rpt.modifier_bits;
    rel = '0;
    prs = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (cur[j] == prev_keys[i]) begin
          held = 1'b1;
        end
      end
      rel[i] = (prev_keys[i] != 8'd0) && !held;
      held = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (prev_keys[j] == cur[i]) begin
          held = 1'b1;
        end
      end
      prs[i] = (cur[i] != 8'd0) && !held;
    end

    needed = 5'($countones({mod_diff, rel, prs}));
    overflow = needed > event_limit;
  end

  assign rpt.ready = !q_full;
  assign accept = rpt.valid && !q_full;
  assign q_push = accept && (!ok || needed != 5'd0);

  always_comb begin
    q_data = '0;
    if (!ok) begin
      q_data.status = ST_INVALID;
    end else if (overflow) begin
      q_data.status = ST_OVERFLOW;
    end else begin
      q_data.status   = ST_EVENT;
      q_data.mod_diff = mod_diff;
      q_data.mod_new  = rpt.modifier_bits;
      q_data.rel_mask = rel;
      q_data.prs_mask = prs;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        q_data.old_keys[i] = prev_keys[i];
        q_data.new_keys[i] = cur[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      event_limit <= cfg_data;
    end
  end

  // The stored report follows every accepted report that is valid and fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_mods <= 8'd0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys[i] <= 8'd0;
      end
    end else if (accept && ok && !overflow) begin
      prev_mods <= rpt.modifier_bits;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        prev_keys[i] <= cur[i];
      end
    end
  end

endmodule
`default_nettype wire

/* sv/bkre_fifo.sv */
// Short queue of work entries between the classifier and the sequencer.
// Depends on bkre_pkg.
`default_nettype none
module bkre_fifo import bkre_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  input  logic  pop,
  output work_t head,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/bkre_back.sv */
// Event sequencer: takes queued work entries and sends one beat per cycle while
// evt is ready, through an output register. Depends on bkre_pkg, bkre_out_if.
`default_nettype none
module bkre_back import bkre_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  work_t     q_data,
  output logic      q_pop,
  bkre_out_if.source evt
);
  `include "boot_keyboard_report_events_core_assert.svh"

  logic    work_valid;
  work_t   work;
  logic    out_valid;
  usage_t  out_usage;
  logic    out_down;
  status_t out_status;
  logic    out_last;

  logic [7:0]           mod_one;
  logic [ALL_SLOTS-1:0] rel_one;
  logic [ALL_SLOTS-1:0] prs_one;
  logic [7:0]           mod_diff_next;
  logic [ALL_SLOTS-1:0] rel_next;
  logic [ALL_SLOTS-1:0] prs_next;
  usage_t               sel_usage;
  logic                 sel_down;
  logic                 sel_last;
  logic                 emit;
  logic                 finish;

  // Lowest pending bit of each mask, isolated as a one-hot word.
  assign mod_one = work.mod_diff & (~work.mod_diff + 8'd1);
  assign rel_one = work.rel_mask & (~work.rel_mask + ALL_SLOTS'(1));
  assign prs_one = work.prs_mask & (~work.prs_mask + ALL_SLOTS'(1));

  always_comb begin
    logic [2:0] bit_idx;
    mod_diff_next = work.mod_diff;
    rel_next      = work.rel_mask;
    prs_next      = work.prs_mask;
    sel_usage     = 8'd0;
    sel_down      = 1'b0;
    bit_idx       = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (mod_one[b]) begin
        bit_idx = 3'(b);
      end
    end
    if (work.status == ST_EVENT) begin
      priority if (work.mod_diff != 8'd0) begin
        sel_usage     = MOD_USAGE_BASE + 8'(bit_idx);
        sel_down      = |(mod_one & work.mod_new);
        mod_diff_next = work.mod_diff & ~mod_one;
      end else if (work.rel_mask != '0) begin
        for (int i = 0; i < ALL_SLOTS; i++) begin
          if (rel_one[i]) begin
            sel_usage = work.old_keys[i];
          end
        end
        rel_next = work.rel_mask & ~rel_one;
      end else begin
        for (int i = 0; i < ALL_SLOTS; i++) begin
          if (prs_one[i]) begin
            sel_usage = work.new_keys[i];
          end
        end
        sel_down = 1'b1;
        prs_next = work.prs_mask & ~prs_one;
      end
    end
    sel_last = (work.status != ST_EVENT) ||
               (mod_diff_next == 8'd0 && rel_next == '0 && prs_next == '0);
  end

  assign emit   = work_valid && (!out_valid || evt.ready);
  assign finish = emit && sel_last;
  assign q_pop  = !q_empty && (!work_valid || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (q_pop) begin
      work_valid <= 1'b1;
    end else if (finish) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_data;
    end else if (emit) begin
      work.mod_diff <= mod_diff_next;
      work.rel_mask <= rel_next;
      work.prs_mask <= prs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_usage  <= sel_usage;
      out_down   <= sel_down;
      out_status <= work.status;
      out_last   <= sel_last;
    end
  end

  assign evt.valid         = out_valid;
  assign evt.event_usage   = out_usage;
  assign evt.key_down      = out_down;
  assign evt.result_status = out_status;
  assign evt.last_event    = out_last;

  `BKRE_ASSERT_IMPLIES(a_status_is_last, clk, rst, out_valid && out_status != ST_EVENT, out_last, "status beat without last mark")
  `BKRE_ASSERT_IMPLIES(a_event_pending, clk, rst, work_valid && work.status == ST_EVENT, (work.mod_diff != 8'd0) || (work.rel_mask != '0) || (work.prs_mask != '0), "event entry held with nothing left to send")
  `BKRE_ASSERT_NEXT(a_drain_idle, clk, rst, finish && q_empty, !work_valid, "sequencer busy after last beat with empty queue")

endmodule
`default_nettype wire

/* bench/boot_keyboard_report_events_check.sv */
`timescale 1ns / 1ps
// Event checker for the boot keyboard report event core: it predicts the beats
// of every accepted report and compares them with the event channel.
// Depends on bkre_pkg and the channel interfaces in bkre_if.
module boot_keyboard_report_events_check import bkre_pkg::*; #(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bkre_in_if         rpt,
  bkre_out_if        evt,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    usage_t  usage;
    logic    pressed;
    status_t status;
    logic    last_beat;
  } key_event_t;

  key_event_t expected_events[$];
  logic [4:0] event_limit;
  logic [7:0] held_mods;
  usage_t     held_keys[ALL_SLOTS];
  int         faults = 0;

  function automatic key_event_t make_beat(usage_t usage, logic pressed, status_t status,
                                           logic last_beat);
    key_event_t beat;
    beat.usage     = usage;
    beat.pressed   = pressed;
    beat.status    = status;
    beat.last_beat = last_beat;
    return beat;
  endfunction

  function automatic logic slot_has(usage_t keys[ALL_SLOTS], usage_t usage);
    for (int i = 0; i < KEY_SLOTS && i < ALL_SLOTS; i++) begin
      if (keys[i] == usage) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the beats of one report and moves the held report on when they fit.
  function automatic void predict_events(logic [7:0] len, logic [7:0] mods, logic [7:0] rsvd,
                                         usage_t keys[ALL_SLOTS]);
    key_event_t batch[$];
    logic       well_formed;
    logic [7:0] mod_change;
    well_formed = (len == REPORT_BYTES) && (rsvd == 8'd0);
    // Every slot is checked, even those beyond KEY_SLOTS.
    for (int i = 0; i < ALL_SLOTS; i++) begin
      if (keys[i] >= ERR_LOW && keys[i] <= ERR_HIGH) begin
        well_formed = 1'b0;
      end else if (keys[i] != 8'd0) begin
        for (int j = i + 1; j < ALL_SLOTS; j++) begin
          if (keys[i] == keys[j]) well_formed = 1'b0;
        end
      end
    end
    if (!well_formed) begin
      expected_events.push_back(make_beat(8'd0, 1'b0, ST_INVALID, 1'b1));
      return;
    end
    mod_change = held_mods ^ mods;
    for (int b = 0; b < 8; b++) begin
      if (mod_change[b]) batch.push_back(make_beat(MOD_USAGE_BASE | usage_t'(b), mods[b],
                                                   ST_EVENT, 1'b0));
    end
    for (int i = 0; i < KEY_SLOTS && i < ALL_SLOTS; i++) begin
      if (held_keys[i] != 8'd0 && !slot_has(keys, held_keys[i]))
        batch.push_back(make_beat(held_keys[i], 1'b0, ST_EVENT, 1'b0));
    end
    for (int i = 0; i < KEY_SLOTS && i < ALL_SLOTS; i++) begin
      if (keys[i] != 8'd0 && !slot_has(held_keys, keys[i]))
        batch.push_back(make_beat(keys[i], 1'b1, ST_EVENT, 1'b0));
    end
    if (batch.size() > int'(event_limit)) begin
      expected_events.push_back(make_beat(8'd0, 1'b0, ST_OVERFLOW, 1'b1));
      return;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last_beat = 1'b1;
    foreach (batch[k]) expected_events.push_back(batch[k]);
    held_mods = mods;
    for (int i = 0; i < ALL_SLOTS; i++) held_keys[i] = (i < KEY_SLOTS) ? keys[i] : 8'd0;
  endfunction

  always @(posedge clk) begin : watch
    usage_t     slots[ALL_SLOTS];
    key_event_t seen;
    key_event_t want;
    if (rst) begin
      expected_events.delete();
      event_limit = LIMIT_RESET;
      held_mods   = 8'd0;
      for (int i = 0; i < ALL_SLOTS; i++) held_keys[i] = 8'd0;
    end else begin
      // Outputs first: a report accepted at this edge cannot have a beat out yet.
      if (evt.valid && evt.ready) begin
        seen.usage     = evt.event_usage;
        seen.pressed   = evt.key_down;
        seen.status    = status_t'(evt.result_status);
        seen.last_beat = evt.last_event;
        if (expected_events.size() == 0) begin
          faults++;
          $display("%0t: unexpected event beat: expected none, got usage %h down %b status %0d last %b",
                   $time, seen.usage, seen.pressed, seen.status, seen.last_beat);
        end else begin
          want = expected_events.pop_front();
          if (seen.usage !== want.usage || seen.pressed !== want.pressed ||
              seen.status !== want.status || seen.last_beat !== want.last_beat) begin
            faults++;
            $display({"%0t: event mismatch: expected usage %h down %b status %0d last %b,",
                      " got usage %h down %b status %0d last %b"},
                     $time, want.usage, want.pressed, want.status, want.last_beat,
                     seen.usage, seen.pressed, seen.status, seen.last_beat);
          end
        end
      end
      if (rpt.valid && rpt.ready) begin
        slots[0] = rpt.key_slot_0;
        slots[1] = rpt.key_slot_1;
        slots[2] = rpt.key_slot_2;
        slots[3] = rpt.key_slot_3;
        slots[4] = rpt.key_slot_4;
        slots[5] = rpt.key_slot_5;
        predict_events(rpt.report_length, rpt.modifier_bits, rpt.reserved_byte, slots);
      end
      // A new limit applies from the report after this edge on.
      if (cfg_we) event_limit = cfg_data;
    end
    mismatches  <= faults;
    outstanding <= expected_events.size();
  end

endmodule

/* bench/boot_keyboard_report_events_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the boot keyboard report event core: clock, reset, report
// stimulus, event back-pressure and limit writes, with the verdict at the end.
// Depends on bkre_pkg, bkre_if, the core and boot_keyboard_report_events_check.
module boot_keyboard_report_events_core_tb;
  import bkre_pkg::*;

  typedef struct packed {
    logic [7:0]      len;
    logic [7:0]      mods;
    logic [7:0]      rsvd;
    logic [5:0][7:0] keys;
  } kb_report_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_data;
  int         mismatches;
  int         outstanding;
  logic       sender_steady   = 1'b0;
  logic       receiver_steady = 1'b0;
  logic       hold_request    = 1'b0;
  kb_report_t typed;  // last well-formed report of the typing sequence

  bkre_in_if  rpt ();
  bkre_out_if evt ();

  boot_keyboard_report_events_core dut (
    .clk      (clk),
    .rst      (rst),
    .rpt      (rpt),
    .evt      (evt),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  boot_keyboard_report_events_check u_check (
    .clk         (clk),
    .rst         (rst),
    .rpt         (rpt),
    .evt         (evt),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Event side: random stalls, steady stretches and one long hold-off on request.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    evt.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        evt.ready <= 1'b0;
        hold_left--;
      end else if (hold_request && !hold_done) begin
        hold_done   = 1'b1;
        hold_left   = 79;
        evt.ready  <= 1'b0;
      end else if (receiver_steady) begin
        evt.ready <= 1'b1;
      end else begin
        evt.ready <= ($urandom_range(99) >= 29);
      end
    end
  end

  function automatic kb_report_t report(logic [7:0] len, logic [7:0] mods, logic [7:0] rsvd,
                                        logic [7:0] k0, logic [7:0] k1, logic [7:0] k2,
                                        logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
    kb_report_t r;
    r.len     = len;
    r.mods    = mods;
    r.rsvd    = rsvd;
    r.keys[0] = k0;
    r.keys[1] = k1;
    r.keys[2] = k2;
    r.keys[3] = k3;
    r.keys[4] = k4;
    r.keys[5] = k5;
    return r;
  endfunction

  // A usable key usage that appears in neither slot set.
  function automatic logic [7:0] fresh_usage(logic [5:0][7:0] a, logic [5:0][7:0] b);
    logic [7:0] u;
    logic       clash;
    do begin
      u     = 8'($urandom_range(255, 4));
      clash = 1'b0;
      for (int i = 0; i < ALL_SLOTS; i++) begin
        if (a[i] == u || b[i] == u) clash = 1'b1;
      end
    end while (clash);
    return u;
  endfunction

  function automatic kb_report_t next_typing(kb_report_t prev);
    kb_report_t r;
    int         pick;
    int         a;
    int         b;
    logic [7:0] tmp;
    r      = prev;
    r.len  = REPORT_BYTES;
    r.rsvd = 8'd0;
    pick   = $urandom_range(99);
    if (pick < 8) return r;
    if (pick < 15) begin
      // Every modifier and every slot changes at once: the largest burst of beats.
      r.mods = ~prev.mods;
      r.keys = '0;
      for (int i = 0; i < ALL_SLOTS; i++) r.keys[i] = fresh_usage(prev.keys, r.keys);
      return r;
    end
    if (pick < 22) begin
      // Same keys in other slots, which is no change at all.
      a         = $urandom_range(ALL_SLOTS - 1);
      b         = $urandom_range(ALL_SLOTS - 1);
      tmp       = r.keys[a];
      r.keys[a] = r.keys[b];
      r.keys[b] = tmp;
      return r;
    end
    r.mods ^= 8'($urandom) & 8'($urandom);
    for (int i = 0; i < ALL_SLOTS; i++) begin
      if ($urandom_range(99) < 35)
        r.keys[i] = $urandom_range(1) ? 8'd0 : fresh_usage(r.keys, r.keys);
    end
    return r;
  endfunction

  function automatic kb_report_t broken(kb_report_t base);
    kb_report_t r;
    int         i;
    int         j;
    r = base;
    case ($urandom_range(4))
      0: begin
        r.len = 8'($urandom);
        if (r.len == REPORT_BYTES) r.len = 8'd9;
      end
      1: r.rsvd = 8'($urandom_range(255, 1));
      2: r.keys[$urandom_range(ALL_SLOTS - 1)] = 8'($urandom_range(ERR_HIGH, ERR_LOW));
      3: begin
        i = $urandom_range(ALL_SLOTS - 1);
        j = (i + 1 + $urandom_range(ALL_SLOTS - 2)) % ALL_SLOTS;
        if (r.keys[i] == 8'd0) r.keys[i] = fresh_usage(r.keys, r.keys);
        r.keys[j] = r.keys[i];
      end
      default: begin
        r.len  = 8'($urandom);
        r.mods = 8'($urandom);
        r.rsvd = 8'($urandom);
        for (int k = 0; k < ALL_SLOTS; k++) r.keys[k] = 8'($urandom);
      end
    endcase
    return r;
  endfunction

  task automatic send_report(kb_report_t r);
    if (!sender_steady) begin
      while ($urandom_range(99) < 29) begin
        rpt.valid <= 1'b0;
        @(posedge clk);
      end
    end
    rpt.valid         <= 1'b1;
    rpt.report_length <= r.len;
    rpt.modifier_bits <= r.mods;
    rpt.reserved_byte <= r.rsvd;
    rpt.key_slot_0    <= r.keys[0];
    rpt.key_slot_1    <= r.keys[1];
    rpt.key_slot_2    <= r.keys[2];
    rpt.key_slot_3    <= r.keys[3];
    rpt.key_slot_4    <= r.keys[4];
    rpt.key_slot_5    <= r.keys[5];
    do @(posedge clk); while (!rpt.ready);
  endtask

  // Mostly well-formed typing, with some broken reports mixed in.
  task automatic run_reports(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 85) begin
        typed = next_typing(typed);
        send_report(typed);
      end else begin
        send_report(broken(typed));
      end
    end
  endtask

  // Waits until every expected beat is out, then lets reports with no beats drain.
  task automatic settle();
    rpt.valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 50000 && outstanding != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [4:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_data          = 5'd0;
    rpt.valid         = 1'b0;
    rpt.report_length = 8'd0;
    rpt.modifier_bits = 8'd0;
    rpt.reserved_byte = 8'd0;
    rpt.key_slot_0    = 8'd0;
    rpt.key_slot_1    = 8'd0;
    rpt.key_slot_2    = 8'd0;
    rpt.key_slot_3    = 8'd0;
    rpt.key_slot_4    = 8'd0;
    rpt.key_slot_5    = 8'd0;
    typed             = report(REPORT_BYTES, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_report(report(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8, 8'hFF, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(report(8, 8'h00, 8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA));
    send_report(report(8, 8'h00, 8'h00, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF));
    send_report(report(8, 8'h81, 8'h00, 8'hFA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(0, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(255, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(7, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(9, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8, 8'h00, 8'hFF, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8, 8'h00, 8'h01, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00));
    send_report(report(8, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03));
    send_report(report(8, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF));
    send_report(report(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h04, 8'h00, 8'h00));
    // A key slot may carry a modifier usage alongside the modifier bit itself.
    send_report(report(8, 8'h01, 8'h00, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    // A zero limit turns any change into an overflow status.
    write_limit(5'd0);
    send_report(report(8, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(report(8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    write_limit(5'd31);
    run_reports(100);
    write_limit(5'd3);
    run_reports(100);

    write_limit(LIMIT_RESET);
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    run_reports(40);
    receiver_steady = 1'b0;
    hold_request    = 1'b1;
    run_reports(30);
    sender_steady   = 1'b0;
    run_reports(40);

    write_limit(5'($urandom_range(31)));
    run_reports(100);

    settle();
    if (outstanding != 0)
      $display("%0t: %0d expected event beats never arrived", $time, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
